>>> design/esk_pkg.sv
package esk_pkg;

   typedef enum logic [1:0] {
      REQ_BYTE    = 2'd0,
      REQ_TIMEOUT = 2'd1,
      REQ_INTR    = 2'd2,
      REQ_WRITE   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_RAW  = 2'd0,
      KIND_KEY  = 2'd1,
      KIND_INTR = 2'd2
   } out_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EREAD,
      ST_ECMP,
      ST_EDONE,
      ST_REPLAY,
      ST_OUT
   } state_type;

   localparam logic [0:0] CSR_FKEY_SUPPRESS = 1'b0;

endpackage

>>> design/esk_ram.sv
module esk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/escape_sequence_key_matcher_top.sv
// channel | beat        | handshake
// req     | one request | req_valid / req_stall
// rsp     | one result  | rsp_valid / rsp_stall
// csr     | reg write   | APB-style, pready tied high
// A received byte scans the table one entry at a time; each entry compares
// its bytes one per cycle through one comparator fed by the sequence RAM.
// The scan stops at the first entry that matches the whole buffer, and an entry stops
// at its first mismatching byte. Replays emit one byte per cycle unless rsp_stall
// holds the output. Writes, interrupts and timeouts do not scan the table.
// reset clears control state and entry lengths; req_stall stays high while busy.
module escape_sequence_key_matcher_top #(
   parameter int MAX_SEQ_LEN   = 31,
   parameter int TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_byte_value,
   input  logic [4:0]  req_entry_index,
   input  logic [4:0]  req_char_pos,
   input  logic [7:0]  req_entry_code,
   input  logic        req_entry_is_fkey,
   input  logic [4:0]  req_entry_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_value,
   output logic        rsp_out_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PW = $clog2(MAX_SEQ_LEN);
   localparam int LW = $clog2(MAX_SEQ_LEN + 1);
   localparam int AW = EW + PW;
   localparam int DEPTH = TABLE_ENTRIES * (1 << PW);
   localparam int EWI = $clog2(TABLE_ENTRIES + 1);

   esk_pkg::state_type state_ff, state_in;
   logic              fkey_ff;
   logic [LW-1:0]     len_ff [TABLE_ENTRIES];
   logic [7:0]        code_ff [TABLE_ENTRIES];
   logic              fk_ff [TABLE_ENTRIES];
   logic [7:0]        buf_ff [MAX_SEQ_LEN];
   logic [LW-1:0]     plen_ff, plen_in;
   logic [EWI-1:0]    ent_ff, ent_in;
   logic [LW-1:0]     pos_ff, pos_in;
   logic              prefix_ff, prefix_in;
   logic              rv_ff, rv_in;
   logic [1:0]        rk_ff, rk_in;
   logic [7:0]        rval_ff, rval_in;
   logic              rl_ff, rl_in;
   logic              accept, csr_wr;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [7:0]        rd_data;
   logic [EW-1:0]     ent_idx;
   logic [LW-1:0]     ent_len;
   logic              ent_skip;
   logic [LW-1:0]     len_sat;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != esk_pkg::ST_IDLE) || rv_ff;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'd0) ? {31'd0, fkey_ff} : 32'd0;

   assign ent_idx = ent_ff[EW-1:0];
   assign ent_len = len_ff[ent_idx];
   assign ent_skip = (ent_len == '0) || (ent_len < plen_ff) || (fkey_ff && fk_ff[ent_idx]);
   assign len_sat = (req_entry_length > 5'(MAX_SEQ_LEN)) ? LW'(MAX_SEQ_LEN)
                                                          : LW'(req_entry_length);

   assign wr_en = accept && (req_type == esk_pkg::REQ_WRITE)
                  && (32'(req_entry_index) < TABLE_ENTRIES)
                  && (32'(req_char_pos) < MAX_SEQ_LEN);
   assign wr_addr = {req_entry_index[EW-1:0], req_char_pos[PW-1:0]};
   // registered read: address the byte that the next cycle compares
   assign rd_addr = {ent_in[EW-1:0], pos_in[PW-1:0]};

   esk_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_seq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= esk_pkg::ST_IDLE;
         fkey_ff   <= 1'b0;
         plen_ff   <= '0;
         rv_ff     <= 1'b0;
         prefix_ff <= 1'b0;
         ent_ff    <= '0;
         pos_ff    <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            len_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         plen_ff   <= plen_in;
         rv_ff     <= rv_in;
         prefix_ff <= prefix_in;
         ent_ff    <= ent_in;
         pos_ff    <= pos_in;
         if (csr_wr && csr_paddr[1:0] == 2'd0) begin
            fkey_ff <= csr_pwdata[0];
         end
         if (accept && req_type == esk_pkg::REQ_WRITE
             && 32'(req_entry_index) < TABLE_ENTRIES) begin
            len_ff[req_entry_index[EW-1:0]] <= len_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      rk_ff   <= rk_in;
      rval_ff <= rval_in;
      rl_ff   <= rl_in;
      if (accept && req_type == esk_pkg::REQ_WRITE
          && 32'(req_entry_index) < TABLE_ENTRIES) begin
         code_ff[req_entry_index[EW-1:0]] <= req_entry_code;
         fk_ff[req_entry_index[EW-1:0]]   <= req_entry_is_fkey;
      end
      if (accept && req_type == esk_pkg::REQ_BYTE && req_byte_value != 8'd0) begin
         buf_ff[(plen_ff >= LW'(MAX_SEQ_LEN)) ? PW'(0) : plen_ff[PW-1:0]] <= req_byte_value;
      end
   end

   always_comb begin
      state_in  = state_ff;
      plen_in   = plen_ff;
      ent_in    = ent_ff;
      pos_in    = pos_ff;
      prefix_in = prefix_ff;
      rv_in     = rv_ff && rsp_stall;
      rk_in     = rk_ff;
      rval_in   = rval_ff;
      rl_in     = rl_ff;
      case (state_ff)
         esk_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  esk_pkg::REQ_INTR: begin
                     plen_in = '0;
                     rv_in   = 1'b1;
                     rk_in   = esk_pkg::KIND_INTR;
                     rval_in = 8'd0;
                     rl_in   = 1'b1;
                  end
                  esk_pkg::REQ_TIMEOUT: begin
                     pos_in = '0;
                     if (plen_ff != '0) state_in = esk_pkg::ST_REPLAY;
                  end
                  esk_pkg::REQ_BYTE: begin
                     if (req_byte_value != 8'd0) begin
                        plen_in   = (plen_ff >= LW'(MAX_SEQ_LEN)) ? LW'(1) : plen_ff + 1'b1;
                        ent_in    = '0;
                        pos_in    = '0;
                        prefix_in = 1'b0;
                        state_in  = esk_pkg::ST_EREAD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         esk_pkg::ST_EREAD: begin
            if (32'(ent_ff) >= TABLE_ENTRIES) begin
               pos_in = '0;
               state_in = prefix_ff ? esk_pkg::ST_IDLE : esk_pkg::ST_REPLAY;
            end else if (ent_skip) begin
               ent_in = ent_ff + 1'b1;
            end else begin
               state_in = esk_pkg::ST_ECMP;
            end
         end
         esk_pkg::ST_ECMP: begin
            if (rd_data != buf_ff[pos_ff[PW-1:0]]) begin
               ent_in = ent_ff + 1'b1;
               pos_in = '0;
               state_in = esk_pkg::ST_EREAD;
            end else if (pos_ff + 1'b1 == plen_ff) begin
               state_in = esk_pkg::ST_EDONE;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = esk_pkg::ST_ECMP;
            end
         end
         esk_pkg::ST_EDONE: begin
            pos_in = '0;
            if (ent_len == plen_ff) begin
               plen_in  = '0;
               rv_in    = 1'b1;
               rk_in    = esk_pkg::KIND_KEY;
               rval_in  = code_ff[ent_idx];
               rl_in    = 1'b1;
               state_in = esk_pkg::ST_OUT;
            end else begin
               prefix_in = 1'b1;
               ent_in    = ent_ff + 1'b1;
               state_in  = esk_pkg::ST_EREAD;
            end
         end
         esk_pkg::ST_REPLAY: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in   = 1'b1;
               rk_in   = esk_pkg::KIND_RAW;
               rval_in = buf_ff[pos_ff[PW-1:0]];
               rl_in   = (pos_ff + 1'b1 == plen_ff);
               pos_in  = pos_ff + 1'b1;
               if (pos_ff + 1'b1 == plen_ff) begin
                  plen_in  = '0;
                  state_in = esk_pkg::ST_OUT;
               end
            end
         end
         esk_pkg::ST_OUT: begin
            state_in = esk_pkg::ST_IDLE;
         end
         default: state_in = esk_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid     = rv_ff;
   assign rsp_out_kind  = rk_ff;
   assign rsp_out_value = rval_ff;
   assign rsp_out_last  = rl_ff;

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != esk_pkg::ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_plen_bound: assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LW'(MAX_SEQ_LEN)) else $error("buffer overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && rsp_stall) |=> (rv_ff && $stable(rval_ff) && $stable(rk_ff)))
      else $error("result lost");

endmodule
